### hw/rtl/trx_pkg.sv
`default_nettype none

package trx_pkg;

	localparam logic [7:0]  STX_BYTE          = 8'h02;
	localparam logic [7:0]  HDR_TAG_BYTE      = 8'h80;
	localparam logic [15:0] CRC_POLY          = 16'h8005;
	localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd100;

	localparam logic        REQ_BYTE          = 1'b0;
	localparam logic        REQ_TICK          = 1'b1;

	localparam logic        STATUS_GOOD       = 1'b0;
	localparam logic        STATUS_TIMEOUT    = 1'b1;

	localparam logic [1:0]  ADDR_IDLE_TIMEOUT = 2'd0;

	typedef struct packed {
		logic        status;
		logic [7:0]  command_byte;
		logic [9:0]  frame_length;
		logic [15:0] frame_checksum;
		logic [15:0] bad_checksum_count;
	} trx_result_t;

	function automatic logic [15:0] crc_step(
		input logic [15:0] crc,
		input logic [7:0]  prev,
		input logic [7:0]  cur
	);
		logic [15:0] c;
		c = {crc[14:0], 1'b0};
		if (crc[15]) begin
			c = c ^ CRC_POLY;
		end
		return c ^ {prev, cur};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/trx_frame_mem.sv
`default_nettype none

module trx_frame_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/trx_ctrl.sv
`default_nettype none

module trx_ctrl #(
	parameter int FRAME_BYTES = 1024,
	parameter int AW          = $clog2(FRAME_BYTES)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 req_type,
	input  wire logic [7:0]           rx_byte,
	input  wire logic [15:0]          idle_timeout,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output trx_pkg::trx_result_t      res,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [7:0]                mem_wdata,
	output logic [AW-1:0]             mem_raddr,
	input  wire logic [7:0]           mem_rdata
);

	localparam int              CW           = $clog2(FRAME_BYTES + 1);
	localparam int              EW           = 17;
	localparam logic [15:0]     LEN_LIMIT    = 16'(FRAME_BYTES - 6);
	localparam logic [CW-1:0]   HELD_FULL    = CW'(FRAME_BYTES);
	localparam logic [CW-1:0]   HDR_BYTES    = CW'(4);
	localparam logic [CW-1:0]   SHADOW_BYTES = CW'(5);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RXLO,
		S_RXHI,
		S_SCAN,
		S_COPY,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         held_q;
	logic [15:0]           crc_q;
	logic [7:0]            prev_q;
	logic [15:0]           idle_q;
	logic [15:0]           fail_q;
	logic [7:0]            hdr_q [5];
	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         base_q;
	logic [CW-1:0]         wr_q;
	logic                  pend_q;
	logic [7:0]            rxlo_q;
	trx_pkg::trx_result_t  res_q;

	logic [15:0]   hdr_len;
	logic          hdr_good;
	logic [EW-1:0] len_p4;
	logic [EW-1:0] len_p6;
	logic          wrap;
	logic [CW-1:0] byte_idx;
	logic          upd_byte;
	logic          upd_copy;
	logic          accept;
	logic [16:0]   tick_next;
	logic [15:0]   rx_word;
	logic [CW-1:0] copy_src;
	logic [CW-1:0] hit_idx;

	assign hdr_len  = {hdr_q[3], hdr_q[2]};
	assign hdr_good = (hdr_q[0] == trx_pkg::STX_BYTE) && (hdr_q[1] == trx_pkg::HDR_TAG_BYTE)
		&& (hdr_len < LEN_LIMIT);
	assign len_p4   = EW'(hdr_len) + EW'(4);
	assign len_p6   = EW'(hdr_len) + EW'(6);
	assign wrap     = (held_q >= HELD_FULL);
	assign byte_idx = wrap ? '0 : held_q;
	assign upd_byte = (byte_idx < HDR_BYTES) || !hdr_good || (EW'(byte_idx) < len_p4);
	assign upd_copy = (wr_q < HDR_BYTES) || !hdr_good || (EW'(wr_q) < len_p4);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign tick_next = {1'b0, idle_q} + 17'd1;
	assign rx_word  = {mem_rdata, rxlo_q};
	assign copy_src = base_q + ptr_q;
	assign hit_idx  = ptr_q - CW'(1);

	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = byte_idx[AW-1:0];
		mem_wdata = rx_byte;
		mem_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				mem_we = accept && (req_type == trx_pkg::REQ_BYTE);
			end
			S_EVAL: begin
				mem_raddr = len_p4[AW-1:0];
			end
			S_RXLO: begin
				mem_raddr = len_p4[AW-1:0] + AW'(1);
			end
			S_COPY: begin
				mem_raddr = copy_src[AW-1:0];
				mem_we    = pend_q;
				mem_waddr = wr_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			default: begin
				mem_raddr = ptr_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
			crc_q   <= '0;
			prev_q  <= '0;
			idle_q  <= '0;
			fail_q  <= '0;
			hdr_q   <= '{default: '0};
			ptr_q   <= '0;
			base_q  <= '0;
			wr_q    <= '0;
			pend_q  <= 1'b0;
			rxlo_q  <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == trx_pkg::REQ_TICK) begin
							if (held_q >= HDR_BYTES) begin
								if (tick_next > {1'b0, idle_timeout}) begin
									held_q                   <= '0;
									crc_q                    <= '0;
									prev_q                   <= '0;
									idle_q                   <= '0;
									res_q.status             <= trx_pkg::STATUS_TIMEOUT;
									res_q.command_byte       <= '0;
									res_q.frame_length       <= '0;
									res_q.frame_checksum     <= '0;
									res_q.bad_checksum_count <= fail_q;
									state_q                  <= S_EMIT;
								end else begin
									idle_q <= tick_next[15:0];
								end
							end
						end else begin
							idle_q <= '0;
							held_q <= byte_idx + CW'(1);
							if (byte_idx < SHADOW_BYTES) begin
								hdr_q[byte_idx[2:0]] <= rx_byte;
							end
							if (upd_byte) begin
								crc_q  <= trx_pkg::crc_step(wrap ? 16'd0 : crc_q,
									wrap ? 8'd0 : prev_q, rx_byte);
								prev_q <= rx_byte;
							end
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (held_q < HDR_BYTES) begin
						state_q <= S_IDLE;
					end else if (!hdr_good) begin
						ptr_q   <= CW'(1);
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end else if (EW'(held_q) < len_p6) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RXLO;
					end
				end
				S_RXLO: begin
					rxlo_q  <= mem_rdata;
					state_q <= S_RXHI;
				end
				S_RXHI: begin
					if (rx_word == crc_q) begin
						res_q.status             <= trx_pkg::STATUS_GOOD;
						res_q.command_byte       <= hdr_q[4];
						res_q.frame_length       <= hdr_len[9:0];
						res_q.frame_checksum     <= rx_word;
						res_q.bad_checksum_count <= fail_q;
						held_q                   <= '0;
						crc_q                    <= '0;
						prev_q                   <= '0;
						idle_q                   <= '0;
						state_q                  <= S_EMIT;
					end else begin
						if (fail_q != trx_pkg::COUNT_MAX) begin
							fail_q <= fail_q + 16'd1;
						end
						ptr_q   <= CW'(1);
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pend_q && (mem_rdata == trx_pkg::STX_BYTE)) begin
						held_q  <= held_q - hit_idx;
						base_q  <= hit_idx;
						ptr_q   <= '0;
						wr_q    <= '0;
						pend_q  <= 1'b0;
						crc_q   <= '0;
						prev_q  <= '0;
						state_q <= S_COPY;
					end else if (ptr_q < held_q) begin
						ptr_q  <= ptr_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						held_q  <= '0;
						crc_q   <= '0;
						prev_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_COPY: begin
					if (pend_q) begin
						if (wr_q < SHADOW_BYTES) begin
							hdr_q[wr_q[2:0]] <= mem_rdata;
						end
						if (upd_copy) begin
							crc_q  <= trx_pkg::crc_step(crc_q, prev_q, mem_rdata);
							prev_q <= mem_rdata;
						end
						wr_q <= wr_q + CW'(1);
					end
					if (pend_q && ((wr_q + CW'(1)) == held_q)) begin
						pend_q  <= 1'b0;
						state_q <= S_EVAL;
					end else if (ptr_q < held_q) begin
						ptr_q  <= ptr_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/telegram_receiver_with_resync_core.sv
`default_nettype none

// Telegram receiver: each input beat is either a received byte or one time tick, and a
// result beat reports a good frame (command byte, length, checksum) or an idle abort. A
// byte is written to the frame buffer and evaluated before the next beat is taken; a byte
// completing a frame also reads its two checksum bytes and waits to pass the result to the
// output register. A tick is handled in the idle state; an aborting tick also waits to hand
// over its result. After a bad header or checksum the frame buffer is rescanned through its
// single read port: it is searched for the next 0x02, the bytes from there are moved down
// to the start, and a rescan can follow a rescan. The frame buffer needs no clearing pass
// after reset. Register idle_timeout_ticks (16 bits, reset 100) lies at byte address 0;
// result beats wait in an output register while the next input beat is taken.
module telegram_receiver_with_resync_core #(
	parameter int FRAME_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic      [7:0]  command_byte,
	output logic      [9:0]  frame_length,
	output logic      [15:0] frame_checksum,
	output logic      [15:0] bad_checksum_count
);

	localparam int AW = $clog2(FRAME_BYTES);

	logic                 cfg_write;
	logic [15:0]          timeout_q;
	logic                 out_valid_q;
	trx_pkg::trx_result_t out_res_q;
	logic                 res_valid;
	logic                 res_ready;
	trx_pkg::trx_result_t res;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [7:0]           mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [7:0]           mem_rdata;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr == trx_pkg::ADDR_IDLE_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= trx_pkg::TIMEOUT_RESET;
		end else if (cfg_write && (paddr == trx_pkg::ADDR_IDLE_TIMEOUT)) begin
			timeout_q <= pwdata[15:0];
		end
	end

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_res_q <= res;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_res_q.status;
	assign command_byte       = out_res_q.command_byte;
	assign frame_length       = out_res_q.frame_length;
	assign frame_checksum     = out_res_q.frame_checksum;
	assign bad_checksum_count = out_res_q.bad_checksum_count;

	trx_ctrl #(
		.FRAME_BYTES (FRAME_BYTES),
		.AW          (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.idle_timeout (timeout_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	trx_frame_mem #(
		.DEPTH (FRAME_BYTES),
		.AW    (AW)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

### hw/rtl/trx_checker.sv
`default_nettype none

module trx_checker #(
	parameter int FRAME_BYTES = 1024
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [1:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        status,
	input wire logic [7:0]  command_byte,
	input wire logic [9:0]  frame_length,
	input wire logic [15:0] frame_checksum,
	input wire logic [15:0] bad_checksum_count
);

	localparam int LEN_LIMIT = FRAME_BYTES - 6;

	logic cfg_wr;
	logic cfg_rd;

	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr == trx_pkg::ADDR_IDLE_TIMEOUT);
	assign cfg_rd = psel && !pwrite && (paddr == trx_pkg::ADDR_IDLE_TIMEOUT);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(command_byte)
			&& $stable(frame_length) && $stable(frame_checksum)
			&& $stable(bad_checksum_count))
		else $error("stalled result beat changed");

	a_abort_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == trx_pkg::STATUS_TIMEOUT) |->
			(command_byte == 8'd0) && (frame_length == 10'd0) && (frame_checksum == 16'd0))
		else $error("abort beat carries frame fields");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == trx_pkg::STATUS_GOOD) |-> (int'(frame_length) < LEN_LIMIT))
		else $error("good frame length out of range");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_wr) && cfg_rd |-> (prdata[15:0] == $past(pwdata[15:0])))
		else $error("timeout register readback mismatch");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("handshake active during reset");

endmodule

bind telegram_receiver_with_resync_core trx_checker #(
	.FRAME_BYTES (FRAME_BYTES)
) u_trx_checker (.*);

`default_nettype wire

### tb/telegram_receiver_with_resync_core_tb.sv
module telegram_receiver_with_resync_core_tb;

	localparam int FRAME_BYTES = 1024;
	localparam int IDLE_PAUSE = 4 * FRAME_BYTES + 64;
	localparam int LONG_HOLD = 600;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef enum logic [1:0] {SHAPE_GOOD, SHAPE_CORRUPT, SHAPE_CUT} frame_shape_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [7:0]  command_byte;
	logic [9:0]  frame_length;
	logic [15:0] frame_checksum;
	logic [15:0] bad_checksum_count;

	logic [7:0]  frame_mem [0:FRAME_BYTES-1];
	int unsigned held_cnt;
	logic [15:0] crc_acc;
	logic [7:0]  crc_prev;
	int unsigned idle_cnt;
	logic [15:0] fail_cnt;
	logic [15:0] timeout_reg;

	trx_pkg::trx_result_t frame_reports [$];
	logic [7:0]  frame_bytes [$];
	int unsigned beats_sent;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit          src_jitter;
	bit          sink_jitter;
	bit          stall_hold_req;

	telegram_receiver_with_resync_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.command_byte(command_byte),
		.frame_length(frame_length),
		.frame_checksum(frame_checksum),
		.bad_checksum_count(bad_checksum_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] prev, logic [7:0] cur);
		logic [16:0] wide;
		wide = {acc, 1'b0};
		if (wide[16]) begin
			wide[15:0] = wide[15:0] ^ trx_pkg::CRC_POLY;
		end
		return wide[15:0] ^ {prev, cur};
	endfunction

	function automatic int unsigned hdr_length();
		return 32'({frame_mem[3], frame_mem[2]});
	endfunction

	function automatic bit header_ok();
		return frame_mem[0] == trx_pkg::STX_BYTE && frame_mem[1] == trx_pkg::HDR_TAG_BYTE &&
			hdr_length() < FRAME_BYTES - 6;
	endfunction

	function automatic int unsigned covered_bytes(int unsigned held);
		if (held < 4 || !header_ok()) begin
			return held;
		end
		if (held > hdr_length() + 4) begin
			return hdr_length() + 4;
		end
		return held;
	endfunction

	function automatic void rebuild_crc();
		int unsigned n;
		n = covered_bytes(held_cnt);
		crc_acc = 16'h0000;
		crc_prev = 8'h00;
		for (int unsigned i = 0; i < n; i++) begin
			crc_acc = crc_fold(crc_acc, crc_prev, frame_mem[i]);
			crc_prev = frame_mem[i];
		end
	endfunction

	function automatic void clear_frame_state();
		held_cnt = 0;
		crc_acc = 16'h0000;
		crc_prev = 8'h00;
		idle_cnt = 0;
	endfunction

	// slide the buffer down to the next start byte, or empty it
	function automatic void rescan();
		for (int unsigned i = 1; i < held_cnt; i++) begin
			if (frame_mem[i] == trx_pkg::STX_BYTE) begin
				for (int unsigned j = 0; j < held_cnt - i; j++) begin
					frame_mem[j] = frame_mem[j + i];
				end
				held_cnt = held_cnt - i;
				rebuild_crc();
				return;
			end
		end
		held_cnt = 0;
		rebuild_crc();
	endfunction

	function automatic void settle_frame();
		int unsigned len;
		logic [15:0] got;
		trx_pkg::trx_result_t r;
		while (1'b1) begin
			if (held_cnt < 4) begin
				return;
			end
			if (!header_ok()) begin
				rescan();
				continue;
			end
			len = hdr_length();
			if (held_cnt < len + 6) begin
				return;
			end
			got = {frame_mem[len + 5], frame_mem[len + 4]};
			if (got != crc_acc) begin
				if (fail_cnt != trx_pkg::COUNT_MAX) begin
					fail_cnt++;
				end
				rescan();
				continue;
			end
			r.status = trx_pkg::STATUS_GOOD;
			r.command_byte = frame_mem[4];
			r.frame_length = len[9:0];
			r.frame_checksum = got;
			r.bad_checksum_count = fail_cnt;
			frame_reports.push_back(r);
			clear_frame_state();
			return;
		end
	endfunction

	function automatic void absorb_beat(logic kind, logic [7:0] value);
		int unsigned slot;
		trx_pkg::trx_result_t r;
		if (kind == trx_pkg::REQ_TICK) begin
			if (held_cnt < 4) begin
				return;
			end
			if (idle_cnt + 1 > timeout_reg) begin
				clear_frame_state();
				r.status = trx_pkg::STATUS_TIMEOUT;
				r.command_byte = 8'h00;
				r.frame_length = 10'd0;
				r.frame_checksum = 16'h0000;
				r.bad_checksum_count = fail_cnt;
				frame_reports.push_back(r);
			end else begin
				idle_cnt = idle_cnt + 1;
			end
		end else begin
			idle_cnt = 0;
			if (held_cnt >= FRAME_BYTES) begin
				clear_frame_state();
			end
			slot = held_cnt;
			frame_mem[slot] = value;
			held_cnt = slot + 1;
			if (slot < covered_bytes(held_cnt)) begin
				crc_acc = crc_fold(crc_acc, crc_prev, value);
				crc_prev = value;
			end
			settle_frame();
		end
	endfunction

	function automatic void compare_field(string what, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
		end
	endfunction

	always @(posedge clk) begin : result_check
		trx_pkg::trx_result_t want;
		if (arst_n === 1'b1) begin
			if (in_valid && !in_stall) begin
				absorb_beat(req_type, rx_byte);
			end
			if (out_valid && !out_stall) begin
				if (frame_reports.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none actual status %0h cmd %0h len %0h",
						$time, status, command_byte, frame_length);
				end else begin
					want = frame_reports.pop_front();
					compare_field("status", 16'(want.status), 16'(status));
					compare_field("command_byte", 16'(want.command_byte), 16'(command_byte));
					compare_field("frame_length", 16'(want.frame_length), 16'(frame_length));
					compare_field("frame_checksum", want.frame_checksum, frame_checksum);
					compare_field("bad_checksum_count", want.bad_checksum_count,
						bad_checksum_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				stall_hold_req = 1'b0;
			end else if (sink_jitter && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 15))
			0, 1: return trx_pkg::STX_BYTE;
			2: return trx_pkg::HDR_TAG_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] crc_over(int unsigned n);
		logic [15:0] acc;
		logic [7:0] prev;
		acc = 16'h0000;
		prev = 8'h00;
		for (int unsigned k = 0; k < n; k++) begin
			acc = crc_fold(acc, prev, frame_bytes[k]);
			prev = frame_bytes[k];
		end
		return acc;
	endfunction

	function automatic void build_frame(int unsigned len, logic [7:0] cmd);
		logic [15:0] c;
		logic [15:0] len16;
		len16 = len[15:0];
		frame_bytes.delete();
		frame_bytes.push_back(trx_pkg::STX_BYTE);
		frame_bytes.push_back(trx_pkg::HDR_TAG_BYTE);
		frame_bytes.push_back(len16[7:0]);
		frame_bytes.push_back(len16[15:8]);
		for (int unsigned k = 0; k < len; k++) begin
			frame_bytes.push_back((k == 0) ? cmd : pick_byte());
		end
		c = crc_over(len + 4);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endfunction

	task automatic send_beat(input logic kind, input logic [7:0] value);
		@(negedge clk);
		if (src_jitter && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		rx_byte <= value;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_beat(trx_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_bytes(input int unsigned cut, input int unsigned tick_pct,
			input int unsigned max_ticks);
		for (int unsigned k = 0; k < cut; k++) begin
			if (k > 0 && $urandom_range(0, 99) < tick_pct) begin
				send_ticks($urandom_range(1, max_ticks));
			end
			send_beat(trx_pkg::REQ_BYTE, frame_bytes[k]);
		end
	endtask

	task automatic send_frame(input int unsigned len, input logic [7:0] cmd,
			input frame_shape_t shape, input int unsigned tick_pct, input int unsigned max_ticks);
		int unsigned pos;
		int unsigned cut;
		build_frame(len, cmd);
		cut = frame_bytes.size();
		if (shape == SHAPE_CORRUPT) begin
			// leave the length bytes alone so a flip never claims a huge body
			pos = $urandom_range(0, len + 3);
			if (pos >= 2) begin
				pos = pos + 2;
			end
			frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
		end else if (shape == SHAPE_CUT) begin
			cut = $urandom_range(1, len + 5);
		end
		send_bytes(cut, tick_pct, max_ticks);
	endtask

	task automatic mixed_traffic(input int unsigned beats, input int unsigned tick_pct,
			input int unsigned max_ticks);
		int unsigned stop_at;
		int unsigned sel;
		int unsigned len;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
			if (sel < 60) begin
				send_frame(len, pick_byte(), SHAPE_GOOD, tick_pct, max_ticks);
			end else if (sel < 75) begin
				send_frame(len, pick_byte(), SHAPE_CORRUPT, tick_pct, max_ticks);
			end else if (sel < 85) begin
				send_frame(len, pick_byte(), SHAPE_CUT, tick_pct, max_ticks);
			end else if (sel < 93) begin
				repeat ($urandom_range(1, 6)) send_beat(trx_pkg::REQ_BYTE, pick_byte());
			end else begin
				send_ticks($urandom_range(1, max_ticks));
			end
		end
	endtask

	task automatic drain_and_pause();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_reports.size() != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_idle_timeout(input logic [15:0] ticks);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= trx_pkg::ADDR_IDLE_TIMEOUT;
		pwdata <= {16'h0000, ticks};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		timeout_reg = ticks;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field("idle_timeout_ticks", ticks, prdata[15:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_header_wait();
		send_ticks(2);
		send_frame(0, 8'h00, SHAPE_GOOD, 100, 1);
	endtask

	task automatic test_field_extremes();
		send_frame(1, 8'h00, SHAPE_GOOD, 0, 1);
		send_frame(1, 8'hFF, SHAPE_GOOD, 0, 1);
		// length one past the largest allowed
		send_beat(trx_pkg::REQ_BYTE, trx_pkg::STX_BYTE);
		send_beat(trx_pkg::REQ_BYTE, trx_pkg::HDR_TAG_BYTE);
		send_beat(trx_pkg::REQ_BYTE, 8'hFA);
		send_beat(trx_pkg::REQ_BYTE, 8'h03);
	endtask

	task automatic test_nested_resync();
		logic [7:0] inner [$];
		logic [15:0] c;
		build_frame(0, 8'h00);
		inner = frame_bytes;
		frame_bytes.delete();
		frame_bytes.push_back(trx_pkg::STX_BYTE);
		frame_bytes.push_back(trx_pkg::HDR_TAG_BYTE);
		frame_bytes.push_back(8'd6);
		frame_bytes.push_back(8'd0);
		foreach (inner[k]) begin
			frame_bytes.push_back(inner[k]);
		end
		c = ~crc_over(10);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
		send_bytes(frame_bytes.size(), 0, 1);
		send_frame(1, 8'hA5, SHAPE_GOOD, 0, 1);
	endtask

	task automatic test_idle_timeout();
		drain_and_pause();
		write_idle_timeout(16'd0);
		send_beat(trx_pkg::REQ_BYTE, trx_pkg::STX_BYTE);
		send_ticks(1);
		send_beat(trx_pkg::REQ_BYTE, trx_pkg::HDR_TAG_BYTE);
		// largest allowed length: the header holds until the abort
		send_beat(trx_pkg::REQ_BYTE, 8'hF9);
		send_beat(trx_pkg::REQ_BYTE, 8'h03);
		send_ticks(1);
		drain_and_pause();
		write_idle_timeout(16'd1);
		send_beat(trx_pkg::REQ_BYTE, trx_pkg::STX_BYTE);
		send_beat(trx_pkg::REQ_BYTE, trx_pkg::HDR_TAG_BYTE);
		send_beat(trx_pkg::REQ_BYTE, 8'h03);
		send_beat(trx_pkg::REQ_BYTE, 8'h00);
		send_ticks(1);
		send_beat(trx_pkg::REQ_BYTE, 8'h22);
		send_ticks(2);
		drain_and_pause();
		write_idle_timeout(16'hFFFF);
		send_frame(3, 8'h5A, SHAPE_GOOD, 100, 250);
		drain_and_pause();
		write_idle_timeout(trx_pkg::TIMEOUT_RESET);
	endtask

	task automatic test_long_frame();
		send_frame(600, pick_byte(), SHAPE_GOOD, 2, 3);
	endtask

	task automatic test_random_traffic();
		mixed_traffic(120, 10, 3);
	endtask

	task automatic test_timeout_settings();
		logic [15:0] picks [5];
		picks = '{16'd1, 16'd2, 16'hFFFF, 16'd0, trx_pkg::TIMEOUT_RESET};
		picks[3] = 16'($urandom_range(3, 40));
		foreach (picks[k]) begin
			drain_and_pause();
			write_idle_timeout(picks[k]);
			mixed_traffic(30, 30, 4);
		end
	endtask

	task automatic test_backpressure();
		stall_hold_req = 1'b1;
		repeat (8) send_frame($urandom_range(0, 3), pick_byte(), SHAPE_GOOD, 0, 1);
	endtask

	task automatic test_steady_stream();
		src_jitter = 1'b0;
		sink_jitter = 1'b0;
		mixed_traffic(60, 10, 2);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = trx_pkg::REQ_BYTE;
		rx_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = trx_pkg::ADDR_IDLE_TIMEOUT;
		pwdata = 32'h0;
		beats_sent = 0;
		mismatches = 0;
		quiet_cycles = 0;
		stall_hold_req = 1'b0;
		src_jitter = 1'b1;
		sink_jitter = 1'b1;
		clear_frame_state();
		fail_cnt = 16'h0000;
		timeout_reg = trx_pkg::TIMEOUT_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_header_wait();
		test_field_extremes();
		test_nested_resync();
		test_idle_timeout();
		test_long_frame();
		test_random_traffic();
		test_timeout_settings();
		test_backpressure();
		test_steady_stream();

		drain_and_pause();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/trx_pkg.sv
hw/rtl/trx_frame_mem.sv
hw/rtl/trx_ctrl.sv
hw/rtl/telegram_receiver_with_resync_core.sv
hw/rtl/trx_checker.sv
tb/telegram_receiver_with_resync_core_tb.sv
